[sv/plane_wave_pulse_field_defines.svh]
// assertion macros for the plane wave pulse field checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef PLANE_WAVE_PULSE_FIELD_DEFINES_SVH
`define PLANE_WAVE_PULSE_FIELD_DEFINES_SVH

// property checked on every rising edge outside reset
`define PWPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define PWPF_ASSERT_NEXT(label, pre, post, msg) \
  `PWPF_ASSERT(label, (pre) |=> (post), msg)

`endif

[sv/pwpf_pkg.sv]
// shared types, constants and tables for the plane wave pulse field block
// no dependencies
package pwpf_pkg;

  localparam int PWPF_INDEX_BITS    = 16;
  localparam int PWPF_FRAC_BITS     = 16;
  localparam int PWPF_CORDIC_STAGES = 18;

  // quotient bits of the segment ratio, 0..2^30
  localparam int DIV_STEPS = 31;
  // cordic datapath width
  localparam int CW = 34;

  localparam logic [31:0] ONE_Q30         = 32'd1073741824;
  localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032875;
  localparam logic [29:0] INV_TWO_PI_Q32  = 30'd683565276;

  // register indexes, byte address is 4*index
  typedef enum logic [2:0] {
    REG_PULSE_START,
    REG_RISE_LENGTH,
    REG_FLAT_LENGTH,
    REG_FALL_LENGTH,
    REG_WAVE_NUMBER,
    REG_CELL_SIZE,
    REG_AMP_COS_POL,
    REG_AMP_SIN_POL
  } pwpf_reg_e;

  typedef enum logic [1:0] {
    SEG_ZERO,
    SEG_RISE,
    SEG_FLAT,
    SEG_FALL
  } pwpf_seg_e;

  // configuration as seen by the lanes, edges precomputed
  typedef struct packed {
    logic signed [31:0] start;
    logic signed [32:0] rise_edge;
    logic signed [33:0] flat_edge;
    logic signed [34:0] tail;
    logic [30:0]        rise;
    logic [30:0]        fall;
    logic [60:0]        kinv;
  } pwpf_cfg_t;

  typedef struct packed {
    logic [31:0] e_y;
    logic [31:0] e_z;
    logic [31:0] b_y;
    logic [31:0] b_z;
  } pwpf_fields_t;

  // atan(2^-i) in q30, rounded
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    unique case (i)
      0:       r = 32'd843314857;
      1:       r = 32'd497837829;
      2:       r = 32'd263043837;
      3:       r = 32'd133525159;
      4:       r = 32'd67021687;
      5:       r = 32'd33543516;
      6:       r = 32'd16775851;
      7:       r = 32'd8388437;
      8:       r = 32'd4194283;
      9:       r = 32'd2097149;
      default: r = 32'd1 << 5'(30 - i);
    endcase
    return r;
  endfunction

endpackage

[sv/pwpf_div_cell.sv]
// one restoring division step of the segment ratio pipeline
// depends on pwpf_pkg
module pwpf_div_cell #(
  parameter int STEP   = 0,
  parameter int SIDE_W = 34
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [30:0]       r_i,
  input  logic [30:0]       d_i,
  input  logic [30:0]       q_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [30:0]       r_o,
  output logic [30:0]       d_o,
  output logic [30:0]       q_o,
  output logic [SIDE_W-1:0] side_o
);
  import pwpf_pkg::*;

  logic [31:0] t;
  logic        ge;
  logic [30:0] r_d;
  logic [30:0] q_d;
  logic [30:0] r_q, d_q, q_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    // first step compares the offset itself, later ones shift in a zero
    t   = (STEP == 0) ? {1'b0, r_i} : {r_i, 1'b0};
    ge  = (t >= {1'b0, d_i});
    r_d = ge ? 31'(t - {1'b0, d_i}) : t[30:0];
    q_d = {q_i[29:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      d_q    <= d_i;
      q_q    <= q_d;
      side_q <= side_i;
    end
  end

  assign r_o    = r_q;
  assign d_o    = d_q;
  assign q_o    = q_q;
  assign side_o = side_q;

endmodule

[sv/pwpf_cordic_cell.sv]
// one rotation-mode cordic micro-rotation with a registered output
// depends on pwpf_pkg
module pwpf_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 2
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [pwpf_pkg::CW-1:0] x_i,
  input  logic signed [pwpf_pkg::CW-1:0] y_i,
  input  logic signed [pwpf_pkg::CW-1:0] a_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic signed [pwpf_pkg::CW-1:0] x_o,
  output logic signed [pwpf_pkg::CW-1:0] y_o,
  output logic signed [pwpf_pkg::CW-1:0] a_o,
  output logic [SIDE_W-1:0]          side_o
);
  import pwpf_pkg::*;

  localparam logic signed [CW-1:0] ATAN = {{(CW-32){1'b0}}, atan_q30(STAGE)};

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_d, y_d, a_d;
  logic signed [CW-1:0] x_q, y_q, a_q;
  logic [SIDE_W-1:0]    side_q;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (a_i >= 0) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      a_d = a_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      a_d = a_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      a_q    <= a_d;
      side_q <= side_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign a_o    = a_q;
  assign side_o = side_q;

endmodule

[sv/pwpf_lane.sv]
// shape G = envelope * cos(k*pos) for one position, fully pipelined
// depends on pwpf_pkg, pwpf_div_cell, pwpf_cordic_cell
module pwpf_lane #(
  parameter int INDEX_BITS    = pwpf_pkg::PWPF_INDEX_BITS,
  parameter int CORDIC_STAGES = pwpf_pkg::PWPF_CORDIC_STAGES
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  pwpf_pkg::pwpf_cfg_t     cfg_i,
  input  logic [INDEX_BITS+31:0]  pos_i,
  output logic signed [31:0]      g_o
);
  import pwpf_pkg::*;

  localparam int POS_W = INDEX_BITS + 32;
  localparam int CMP_W = POS_W + 1;
  localparam int SIDE_W = 34;

  // stage 1: segment decision and phase partial products
  logic signed [CMP_W-1:0] ps, st, re, fe, tl;
  pwpf_seg_e   seg_d, seg1_q;
  logic [POS_W-1:0] pos1_q;
  logic [63:0] pp00_d, pp00_q;
  logic [31:0] pp01_d, pp01_q, pp10_d, pp10_q;

  always_comb begin
    ps = $signed({1'b0, pos_i});
    st = CMP_W'(cfg_i.start);
    re = CMP_W'(cfg_i.rise_edge);
    fe = CMP_W'(cfg_i.flat_edge);
    tl = CMP_W'(cfg_i.tail);
    // a position on an edge belongs to the segment behind it
    priority if (ps > st) seg_d = SEG_ZERO;
    else if (ps > re)     seg_d = SEG_RISE;
    else if (ps > fe)     seg_d = SEG_FLAT;
    else if (ps > tl)     seg_d = SEG_FALL;
    else                  seg_d = SEG_ZERO;
    pp00_d = 64'(cfg_i.kinv[31:0]) * 64'(pos_i[31:0]);
    pp01_d = cfg_i.kinv[31:0] * 32'(pos_i[POS_W-1:32]);
    pp10_d = 32'(cfg_i.kinv[60:32]) * pos_i[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg1_q <= seg_d;
      pos1_q <= pos_i;
      pp00_q <= pp00_d;
      pp01_q <= pp01_d;
      pp10_q <= pp10_d;
    end
  end

  // stage 2: offset into the segment and phase in turns (q0.32)
  logic signed [CMP_W-1:0] ps1, off_full;
  logic [30:0] off_q, len_q;
  logic [SIDE_W-1:0] side2_q;
  logic [31:0] turns;

  always_comb begin
    ps1      = $signed({1'b0, pos1_q});
    off_full = (seg1_q == SEG_RISE) ? (st - ps1) : (ps1 - tl);
    turns    = pp00_q[63:32] + pp01_q + pp10_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_q   <= off_full[30:0];
      // empty segments never reach the divider result, so a zero divisor is harmless
      len_q   <= (seg1_q == SEG_RISE) ? cfg_i.rise : cfg_i.fall;
      side2_q <= {seg1_q, turns};
    end
  end

  // segment ratio u = offset * 2^30 / length
  logic [30:0] dr [0:DIV_STEPS];
  logic [30:0] dd [0:DIV_STEPS];
  logic [30:0] dq [0:DIV_STEPS];
  logic [SIDE_W-1:0] ds [0:DIV_STEPS];

  assign dr[0] = off_q;
  assign dd[0] = len_q;
  assign dq[0] = '0;
  assign ds[0] = side2_q;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    pwpf_div_cell #(.STEP(j), .SIDE_W(SIDE_W)) u_cell (
      .clk_i,
      .en_i,
      .r_i    (dr[j]),
      .d_i    (dd[j]),
      .q_i    (dq[j]),
      .side_i (ds[j]),
      .r_o    (dr[j+1]),
      .d_o    (dd[j+1]),
      .q_o    (dq[j+1]),
      .side_o (ds[j+1])
    );
  end

  // angle stage: fractions of a quarter turn to radians
  logic [61:0] pe, pp;
  logic signed [CW-1:0] ae_q, ap_q;
  pwpf_seg_e   seg_a_q;
  logic [1:0]  quad_a_q;
  logic [31:0] turns_r;

  always_comb begin
    turns_r = ds[DIV_STEPS][31:0];
    pe = 62'(dq[DIV_STEPS]) * 62'(HALF_PI_Q30);
    pp = 62'(turns_r[29:0]) * 62'(HALF_PI_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ae_q     <= {{(CW-32){1'b0}}, pe[61:30]};
      ap_q     <= {{(CW-32){1'b0}}, pp[61:30]};
      seg_a_q  <= pwpf_seg_e'(ds[DIV_STEPS][33:32]);
      quad_a_q <= turns_r[31:30];
    end
  end

  // two cordic chains side by side: envelope sine and carrier phase
  logic signed [CW-1:0] ex [0:CORDIC_STAGES];
  logic signed [CW-1:0] ey [0:CORDIC_STAGES];
  logic signed [CW-1:0] ea [0:CORDIC_STAGES];
  logic [1:0]           es [0:CORDIC_STAGES];
  logic signed [CW-1:0] px [0:CORDIC_STAGES];
  logic signed [CW-1:0] py [0:CORDIC_STAGES];
  logic signed [CW-1:0] pa [0:CORDIC_STAGES];
  logic [1:0]           psd [0:CORDIC_STAGES];

  assign ex[0]  = {{(CW-32){1'b0}}, CORDIC_GAIN_Q30};
  assign ey[0]  = '0;
  assign ea[0]  = ae_q;
  assign es[0]  = seg_a_q;
  assign px[0]  = {{(CW-32){1'b0}}, CORDIC_GAIN_Q30};
  assign py[0]  = '0;
  assign pa[0]  = ap_q;
  assign psd[0] = quad_a_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    pwpf_cordic_cell #(.STAGE(i), .SIDE_W(2)) u_env (
      .clk_i,
      .en_i,
      .x_i    (ex[i]),
      .y_i    (ey[i]),
      .a_i    (ea[i]),
      .side_i (es[i]),
      .x_o    (ex[i+1]),
      .y_o    (ey[i+1]),
      .a_o    (ea[i+1]),
      .side_o (es[i+1])
    );
    pwpf_cordic_cell #(.STAGE(i), .SIDE_W(2)) u_phase (
      .clk_i,
      .en_i,
      .x_i    (px[i]),
      .y_i    (py[i]),
      .a_i    (pa[i]),
      .side_i (psd[i]),
      .x_o    (px[i+1]),
      .y_o    (py[i+1]),
      .a_o    (pa[i+1]),
      .side_o (psd[i+1])
    );
  end

  // post stage: sin^2 envelope and quadrant fold of the carrier
  localparam logic signed [CW-1:0] ONE = {{(CW-32){1'b0}}, ONE_Q30};

  logic signed [CW-1:0] es_c, pc_c, ps_c, neg_t;
  logic [30:0] s_u;
  logic [61:0] sq;
  logic [30:0] env_d, env_q;
  logic signed [31:0] cos_d, cos_q;

  always_comb begin
    es_c = (ey[CORDIC_STAGES] > ONE) ? ONE :
           (ey[CORDIC_STAGES] < 0) ? '0 : ey[CORDIC_STAGES];
    s_u  = es_c[30:0];
    sq   = 62'(s_u) * 62'(s_u);
    unique case (pwpf_seg_e'(es[CORDIC_STAGES]))
      SEG_RISE, SEG_FALL: env_d = sq[60:30];
      SEG_FLAT:           env_d = ONE_Q30[30:0];
      default:            env_d = '0;
    endcase

    pc_c = (px[CORDIC_STAGES] > ONE) ? ONE :
           (px[CORDIC_STAGES] < -ONE) ? -ONE : px[CORDIC_STAGES];
    ps_c = (py[CORDIC_STAGES] > ONE) ? ONE :
           (py[CORDIC_STAGES] < -ONE) ? -ONE : py[CORDIC_STAGES];
    unique case (psd[CORDIC_STAGES])
      2'd0:    neg_t = pc_c;
      2'd1:    neg_t = -ps_c;
      2'd2:    neg_t = -pc_c;
      default: neg_t = ps_c;
    endcase
    cos_d = neg_t[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      env_q <= env_d;
      cos_q <= cos_d;
    end
  end

  // shape stage
  logic signed [63:0] gp;
  logic signed [31:0] g_q;

  assign gp = 64'($signed({1'b0, env_q})) * 64'(cos_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_q <= gp[61:30];
    end
  end

  assign g_o = g_q;

endmodule

[sv/plane_wave_pulse_field.sv]
// Plane wave pulse field generator, top level.
// Input channel (in_valid_i/in_ready_o, cell_x_i): one word per cell column.
// Output channel (out_valid_o/out_ready_i): one word with e_y, e_z at
// z = cell_x*cell_size and b_y, b_z at the staggered point half a cell on.
// Registers sit on an APB-style port (byte address 4*i), written in the
// access cycle; pready is tied high and reads return the stored value.
// Each word passes the position registers, the two lanes (with the 31-step ratio
// divider chain and the cordic chain) and the amplitude products to out_valid_o.
// Throughput: one word per cycle unless stalled; every stage holds a word.
// The output register is backed by a one-word skid register, so a new word
// is taken while a finished one waits; in_ready_o drops only once the skid
// register is full, and the whole pipeline then freezes until it drains.
// Reset clears all valid state and loads the register defaults; registers
// must be written only with no word in flight.
module plane_wave_pulse_field #(
  parameter int INDEX_BITS    = pwpf_pkg::PWPF_INDEX_BITS,
  parameter int CORDIC_STAGES = pwpf_pkg::PWPF_CORDIC_STAGES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [INDEX_BITS-1:0] cell_x_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    e_y_o,
  output logic signed [31:0]    e_z_o,
  output logic signed [31:0]    b_y_o,
  output logic signed [31:0]    b_z_o
);
  import pwpf_pkg::*;

  localparam int POS_W    = INDEX_BITS + 32;
  localparam int LANE_LAT = 36 + CORDIC_STAGES;
  localparam int DEPTH    = 3 + LANE_LAT;

  localparam logic [30:0] ONE_LEN = 31'(1) << PWPF_FRAC_BITS;

  // configuration registers
  logic signed [31:0] start_q, amp_cos_q, amp_sin_q;
  logic [30:0] rise_q, flat_q, fall_q, wave_q, cell_q;
  logic        wr;
  pwpf_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = pwpf_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      rise_q    <= ONE_LEN;
      flat_q    <= '0;
      fall_q    <= ONE_LEN;
      wave_q    <= ONE_LEN;
      cell_q    <= ONE_LEN;
      amp_cos_q <= '0;
      amp_sin_q <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_PULSE_START: start_q   <= pwdata;
        REG_RISE_LENGTH: rise_q    <= pwdata[30:0];
        REG_FLAT_LENGTH: flat_q    <= pwdata[30:0];
        REG_FALL_LENGTH: fall_q    <= pwdata[30:0];
        REG_WAVE_NUMBER: wave_q    <= pwdata[30:0];
        REG_CELL_SIZE:   cell_q    <= pwdata[30:0];
        REG_AMP_COS_POL: amp_cos_q <= pwdata;
        default:         amp_sin_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PULSE_START: prdata = start_q;
      REG_RISE_LENGTH: prdata = {1'b0, rise_q};
      REG_FLAT_LENGTH: prdata = {1'b0, flat_q};
      REG_FALL_LENGTH: prdata = {1'b0, fall_q};
      REG_WAVE_NUMBER: prdata = {1'b0, wave_q};
      REG_CELL_SIZE:   prdata = {1'b0, cell_q};
      REG_AMP_COS_POL: prdata = amp_cos_q;
      default:         prdata = amp_sin_q;
    endcase
  end

  // derived configuration: segment edges and k/(2*pi)
  pwpf_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d.start     = start_q;
    cfg_d.rise_edge = 33'(start_q) - $signed({2'b0, rise_q});
    cfg_d.flat_edge = 34'(cfg_d.rise_edge) - $signed({3'b0, flat_q});
    cfg_d.tail      = 35'(cfg_d.flat_edge) - $signed({4'b0, fall_q});
    cfg_d.rise      = rise_q;
    cfg_d.fall      = fall_q;
    cfg_d.kinv      = 61'(wave_q) * 61'(INV_TWO_PI_Q32);
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  // pipeline control
  logic             en;
  logic [DEPTH-1:0] vld_q;
  logic             skid_v_q, out_v_q;

  assign en         = ~skid_v_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // positions
  logic [INDEX_BITS+30:0] z1_q;
  logic [POS_W-1:0]       ze_q, zb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_q <= (INDEX_BITS+31)'(cell_x_i) * (INDEX_BITS+31)'(cell_q);
      ze_q <= POS_W'(z1_q);
      zb_q <= POS_W'(z1_q) + POS_W'(cell_q[30:1]);
    end
  end

  logic signed [31:0] g_e, g_b;

  pwpf_lane #(.INDEX_BITS(INDEX_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_e (
    .clk_i,
    .en_i  (en),
    .cfg_i (cfg_q),
    .pos_i (ze_q),
    .g_o   (g_e)
  );

  pwpf_lane #(.INDEX_BITS(INDEX_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_lane_b (
    .clk_i,
    .en_i  (en),
    .cfg_i (cfg_q),
    .pos_i (zb_q),
    .g_o   (g_b)
  );

  // amplitude products
  logic signed [63:0] p_ey_q, p_ez_q, p_by_q, p_bz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ey_q <= 64'(amp_cos_q) * 64'(g_e);
      p_ez_q <= 64'(amp_sin_q) * 64'(g_e);
      p_by_q <= 64'(amp_sin_q) * 64'(g_b);
      p_bz_q <= 64'(amp_cos_q) * 64'(g_b);
    end
  end

  function automatic logic [31:0] sat_q30(input logic signed [63:0] p, input logic neg);
    logic signed [63:0] t;
    logic signed [33:0] v;
    t = neg ? -p : p;
    v = t[63:30];
    if (v > 34'sd2147483647)       return 32'h7fffffff;
    else if (v < -34'sd2147483648) return 32'h80000000;
    else                           return v[31:0];
  endfunction

  pwpf_fields_t pipe_w, out_q, skid_q;

  always_comb begin
    pipe_w.e_y = sat_q30(p_ey_q, 1'b0);
    pipe_w.e_z = sat_q30(p_ez_q, 1'b0);
    pipe_w.b_y = sat_q30(p_by_q, 1'b1);
    pipe_w.b_z = sat_q30(p_bz_q, 1'b0);
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
      out_q    <= '0;
      skid_q   <= '0;
    end else begin
      if (skid_v_q) begin
        if (!out_v_q || out_ready_i) begin
          out_q    <= skid_q;
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end
      end else if (vld_q[DEPTH-1]) begin
        if (!out_v_q || out_ready_i) begin
          out_q   <= pipe_w;
          out_v_q <= 1'b1;
        end else begin
          skid_q   <= pipe_w;
          skid_v_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign e_y_o       = out_q.e_y;
  assign e_z_o       = out_q.e_z;
  assign b_y_o       = out_q.b_y;
  assign b_z_o       = out_q.b_z;

endmodule

[sv/pwpf_checker.sv]
// port-level checks for the plane wave pulse field block, bound to the top
// depends on plane_wave_pulse_field_defines.svh and pwpf_pkg
`include "plane_wave_pulse_field_defines.svh"

module pwpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] e_y_o
);
  import pwpf_pkg::*;

  `PWPF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output word dropped")
  `PWPF_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(e_y_o), "stalled word changed")
  `PWPF_ASSERT(a_stall_only_when_full, !in_ready_o |-> out_valid_o, "input stalled with output empty")
  `PWPF_ASSERT(a_start_readback, (psel && penable && pwrite && paddr[4:2] == REG_PULSE_START) ##1 (paddr[4:2] == REG_PULSE_START) |-> prdata == $past(pwdata), "pulse start readback wrong")
  `PWPF_ASSERT(a_pready, pready, "pready low")

endmodule

bind plane_wave_pulse_field pwpf_checker u_pwpf_checker (.*);
